// ----- src/cou_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cou_pkg: shared types and constants of the camera orientation update
// Beat formats, fixed-point widths, the CORDIC arctangent table and the
// rounding helpers used by the top module.
// ----------------------------------------------------------------------------
package cou_pkg;

    localparam int ANGLE_FRAC_BITS  = 7;
    localparam int VECTOR_FRAC_BITS = 14;
    localparam int IN_FRAC          = 30;
    localparam int CORDIC_STEPS     = 16;
    localparam int STEP_W           = $clog2(CORDIC_STEPS);

    localparam int FIELD_W   = VECTOR_FRAC_BITS + 2;
    localparam int OFFSET_W  = 16;
    localparam int SENS_W    = 16;
    localparam int YAW_W     = 16;
    localparam int PITCH_W   = 15;
    localparam int DELTA_W   = 24;
    localparam int WRAP_W    = 25;
    localparam int ANG_W     = 27;
    localparam int VW        = 33;
    localparam int PW        = 2 * VW;
    localparam int ROOT_W    = 64;
    localparam int LEN_W     = 32;
    localparam int NUM_W     = 63;
    localparam int QUO_STEPS = 31;

    localparam int ANGLE_SHIFT = 16 - ANGLE_FRAC_BITS;
    localparam int FULL_TURN   = 360 << ANGLE_FRAC_BITS;
    localparam int PITCH_LIM   = 89 << ANGLE_FRAC_BITS;
    localparam int WRAP_STEPS  = 9;
    localparam int WRAP_BIAS   = FULL_TURN << (WRAP_STEPS - 1);
    localparam int UP_SHIFT    = IN_FRAC - VECTOR_FRAC_BITS;

    localparam logic [SENS_W-1:0] SENS_RESET = 16'd3277;
    localparam logic signed [VW-1:0] CORDIC_GAIN = 33'sd652032874;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [PW-1:0] prod_t;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] x_offset;
        logic signed [OFFSET_W-1:0] y_offset;
    } in_beat_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] front_x;
        logic signed [FIELD_W-1:0] front_y;
        logic signed [FIELD_W-1:0] front_z;
        logic signed [FIELD_W-1:0] right_x;
        logic signed [FIELD_W-1:0] right_y;
        logic signed [FIELD_W-1:0] right_z;
        logic signed [FIELD_W-1:0] up_x;
        logic signed [FIELD_W-1:0] up_y;
        logic signed [FIELD_W-1:0] up_z;
    } out_beat_t;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } rd_op_t;

    typedef struct packed {
        logic   start;
        rd_op_t op;
    } rd_cmd_t;

    // Arctangent of 2^-i in degrees, Q16.
    function automatic logic [21:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [21:0] r;
        case (i)
            4'd0:    r = 22'd2949120;
            4'd1:    r = 22'd1740967;
            4'd2:    r = 22'd919879;
            4'd3:    r = 22'd466945;
            4'd4:    r = 22'd234379;
            4'd5:    r = 22'd117304;
            4'd6:    r = 22'd58666;
            4'd7:    r = 22'd29335;
            4'd8:    r = 22'd14668;
            4'd9:    r = 22'd7334;
            4'd10:   r = 22'd3667;
            4'd11:   r = 22'd1833;
            4'd12:   r = 22'd917;
            4'd13:   r = 22'd458;
            4'd14:   r = 22'd229;
            default: r = 22'd115;
        endcase
        return r;
    endfunction

    // Round a product back to Q30 (add half, floor shift).
    function automatic vec_t round_q30(input prod_t v);
        prod_t t;
        t = (v + (prod_t'(1) <<< (IN_FRAC - 1))) >>> IN_FRAC;
        return t[VW-1:0];
    endfunction

    // Round Q30 to the output format and saturate to plus or minus one.
    function automatic logic signed [FIELD_W-1:0] to_out(input vec_t v);
        logic signed [VW:0] t;
        t = ((VW + 1)'(v) + (VW + 1)'(1 <<< (UP_SHIFT - 1))) >>> UP_SHIFT;
        if (t > (VW + 1)'(1 << VECTOR_FRAC_BITS)) begin
            t = (VW + 1)'(1 << VECTOR_FRAC_BITS);
        end
        if (t < -(VW + 1)'(1 << VECTOR_FRAC_BITS)) begin
            t = -(VW + 1)'(1 << VECTOR_FRAC_BITS);
        end
        return t[FIELD_W-1:0];
    endfunction

    function automatic vec_t vmag(input vec_t v);
        return v[VW-1] ? -v : v;
    endfunction

endpackage

// ----- src/cou_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cou_cordic: iterative rotation CORDIC in degrees
// Folds the angle into plus or minus 90 degrees and runs one micro-rotation
// per cycle; cosine and sine hold after done until the next start.
// ----------------------------------------------------------------------------
module cou_cordic
    import cou_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    done,
    output vec_t                    cos_out,
    output vec_t                    sin_out
);

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);

    logic                    busy_reg;
    logic                    done_reg;
    logic                    neg_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [ANG_W-1:0] a_reg;
    vec_t                    x_reg;
    vec_t                    y_reg;

    logic signed [ANG_W-1:0] a_fold;
    logic                    neg_fold;
    logic signed [ANG_W-1:0] atan_step;
    vec_t                    xs;
    vec_t                    ys;

    always_comb begin
        a_fold   = angle;
        neg_fold = 1'b0;
        if (a_fold > DEG180) begin
            a_fold = a_fold - DEG360;
        end
        if (a_fold > DEG90) begin
            a_fold   = a_fold - DEG180;
            neg_fold = 1'b1;
        end else if (a_fold < -DEG90) begin
            a_fold   = a_fold + DEG180;
            neg_fold = 1'b1;
        end
        atan_step = ANG_W'($signed({1'b0, atan_deg(step_reg)}));
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a_fold;
                neg_reg  <= neg_fold;
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!a_reg[ANG_W-1]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    a_reg <= a_reg - atan_step;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    a_reg <= a_reg + atan_step;
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

endmodule

// ----- src/cou_root_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cou_root_div: shared square root and divider
// One subtract and compare per cycle serves both a bit-pair integer square
// root (32 steps) and a restoring division with a 31-bit quotient.
// ----------------------------------------------------------------------------
module cou_root_div
    import cou_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  rd_cmd_t           cmd,
    input  logic [ROOT_W-1:0] rad_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [LEN_W-1:0]  den_in,
    output logic              done,
    output logic [LEN_W-1:0]  result
);

    logic              busy_reg;
    logic              done_reg;
    rd_op_t            op_reg;
    logic [4:0]        cnt_reg;
    logic [ROOT_W-1:0] v_reg;
    logic [ROOT_W-1:0] r_reg;
    logic [ROOT_W-1:0] bit_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  den_reg;

    logic [LEN_W:0]    shifted;
    logic [ROOT_W-1:0] sub_a;
    logic [ROOT_W-1:0] sub_b;
    logic [ROOT_W:0]   diff;
    logic              ge;

    always_comb begin
        shifted = {rem_reg, v_reg[QUO_STEPS-1]};
        if (op_reg == RD_SQRT) begin
            sub_a = v_reg;
            sub_b = r_reg + bit_reg;
        end else begin
            sub_a = ROOT_W'(shifted);
            sub_b = ROOT_W'(den_reg);
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = !diff[ROOT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                op_reg   <= cmd.op;
                busy_reg <= 1'b1;
                r_reg    <= '0;
                if (cmd.op == RD_SQRT) begin
                    v_reg   <= rad_in;
                    bit_reg <= ROOT_W'(1) << (ROOT_W - 2);
                    cnt_reg <= 5'(ROOT_W / 2 - 1);
                end else begin
                    v_reg   <= ROOT_W'(num_in[QUO_STEPS-1:0]);
                    rem_reg <= num_in[NUM_W-1:QUO_STEPS];
                    den_reg <= den_in;
                    cnt_reg <= 5'(QUO_STEPS - 1);
                end
            end else if (busy_reg) begin
                if (op_reg == RD_SQRT) begin
                    if (ge) begin
                        v_reg <= diff[ROOT_W-1:0];
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end else begin
                    rem_reg <= ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
                    r_reg   <= {r_reg[ROOT_W-2:0], ge};
                    v_reg   <= v_reg << 1;
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg[LEN_W-1:0];

endmodule

// ----- src/camera_orientation_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_orientation_update: yaw/pitch camera basis from mouse deltas
// Integrates scaled mouse deltas into yaw and pitch and rebuilds the
// front, right and up vectors in Q1.14.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one beat of x_offset and y_offset (counts). Each beat
// yields exactly one m_ beat holding front, right and up, nine Q1.14 fields.
// The cfg_ channel writes the sensitivity register (degrees per count,
// unsigned Q0.16); it is always ready and should be written while idle.
// Most of the work on a beat from acceptance to its result is in the
// shared square root and divider: each of the three normalizations
// needs one 32-step root and three 31-step divisions. The two CORDIC runs
// take 16 iterations each, all products go through one 33x33 multiplier.
// s_ready is high only while the sequencer is idle, so it works on one beat
// at a time. The result sits in an output register: while the
// receiver stalls, the next beat is accepted and computed, and the sequencer
// waits at its last step until the output register is free.
// Reset restores sensitivity 3277, yaw and pitch zero and up (0, 1, 0).
// ----------------------------------------------------------------------------
module camera_orientation_update
    import cou_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_beat_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_beat_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SENS_W-1:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCALE_X, ST_SCALE_Y, ST_ANGLES, ST_WRAP,
        ST_YAW_GO, ST_YAW_WAIT, ST_PITCH_GO, ST_PITCH_WAIT,
        ST_FRONT_A, ST_FRONT_B, ST_FRONT_C, ST_SQ,
        ST_ROOT_GO, ST_ROOT_WAIT, ST_DIV_GO, ST_DIV_WAIT,
        ST_NORM_DONE, ST_CROSS, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_FRONT, PH_RIGHT, PH_UP
    } phase_t;

    state_t                       state_reg;
    phase_t                       phase_reg;
    logic [SENS_W-1:0]            sens_reg;
    logic [YAW_W-1:0]             yaw_reg;
    logic signed [PITCH_W-1:0]    pitch_reg;
    logic signed [FIELD_W-1:0]    up_reg [3];
    logic signed [OFFSET_W-1:0]   x_reg;
    logic signed [OFFSET_W-1:0]   y_reg;
    logic signed [DELTA_W-1:0]    dx_reg;
    logic [WRAP_W-1:0]            wrap_reg;
    logic [3:0]                   k_reg;
    logic [2:0]                   cnt_reg;
    vec_t                         cy_reg, sy_reg, cp_reg, sp_reg;
    vec_t                         w_reg [3];
    vec_t                         front_reg [3];
    vec_t                         right_reg [3];
    prod_t                        prod_reg;
    prod_t                        acc_reg;
    logic [LEN_W-1:0]             len_reg;
    logic                         m_valid_reg;
    out_beat_t                    m_data_reg;

    vec_t                         mul_a, mul_b;
    vec_t                         cross_a [3];
    vec_t                         cross_b [3];
    logic [2:0]                   jdx;
    logic signed [DELTA_W-1:0]    dy;
    logic signed [WRAP_W:0]       ysum;
    logic signed [WRAP_W-1:0]     psum;
    logic [WRAP_W-1:0]            wrap_lim;
    logic [WRAP_W-1:0]            wrap_next;
    prod_t                        rnd9;
    vec_t                         wmag;
    logic                         out_free;

    logic                         cordic_start;
    logic signed [ANG_W-1:0]      cordic_angle;
    logic                         cordic_done;
    vec_t                         cordic_cos, cordic_sin;

    rd_cmd_t                      rd_cmd;
    logic [NUM_W-1:0]             rd_num;
    logic                         rd_done;
    logic [LEN_W-1:0]             rd_result;

    function automatic logic [1:0] cross_ai(input logic [2:0] j);
        logic [1:0] r;
        case (j)
            3'd0, 3'd5: r = 2'd1;
            3'd1, 3'd2: r = 2'd2;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] cross_bi(input logic [2:0] j);
        logic [1:0] r;
        case (j)
            3'd0, 3'd3: r = 2'd2;
            3'd1, 3'd4: r = 2'd1;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (phase_reg == PH_RIGHT) begin
                cross_a[i] = front_reg[i];
                cross_b[i] = vec_t'($signed({up_reg[i], {UP_SHIFT{1'b0}}}));
            end else begin
                cross_a[i] = right_reg[i];
                cross_b[i] = front_reg[i];
            end
        end
        jdx  = (cnt_reg == '0) ? 3'd0 : cnt_reg - 3'd1;
        wmag = vmag(w_reg[cnt_reg[1:0]]);

        mul_a = wmag;
        mul_b = wmag;
        case (state_reg)
            ST_SCALE_X: begin
                mul_a = VW'(x_reg);
                mul_b = VW'($signed({1'b0, sens_reg}));
            end
            ST_SCALE_Y: begin
                mul_a = VW'(y_reg);
                mul_b = VW'($signed({1'b0, sens_reg}));
            end
            ST_FRONT_A: begin
                mul_a = cy_reg;
                mul_b = cp_reg;
            end
            ST_FRONT_B: begin
                mul_a = sy_reg;
                mul_b = cp_reg;
            end
            ST_CROSS: begin
                mul_a = cross_a[cross_ai(cnt_reg)];
                mul_b = cross_b[cross_bi(cnt_reg)];
            end
            default: begin
                mul_a = wmag;
                mul_b = wmag;
            end
        endcase

        // Delta rounding: add half, floor shift.
        rnd9 = (prod_reg + (prod_t'(1) <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
        dy   = rnd9[DELTA_W-1:0];
        ysum = (WRAP_W + 1)'($signed({1'b0, yaw_reg})) + (WRAP_W + 1)'(dx_reg)
             + (WRAP_W + 1)'(WRAP_BIAS);
        psum = WRAP_W'(pitch_reg) + WRAP_W'(dy);

        wrap_lim  = WRAP_W'(FULL_TURN) << k_reg;
        wrap_next = (wrap_reg >= wrap_lim) ? wrap_reg - wrap_lim : wrap_reg;

        cordic_start = (state_reg == ST_YAW_GO) || (state_reg == ST_PITCH_GO);
        if (state_reg == ST_YAW_GO) begin
            cordic_angle = ANG_W'({yaw_reg, {ANGLE_SHIFT{1'b0}}});
        end else begin
            cordic_angle = ANG_W'($signed({pitch_reg, {ANGLE_SHIFT{1'b0}}}));
        end

        rd_cmd.start = (state_reg == ST_ROOT_GO)
                    || ((state_reg == ST_DIV_GO) && (len_reg != '0));
        rd_cmd.op    = (state_reg == ST_ROOT_GO) ? RD_SQRT : RD_DIV;
        rd_num       = (NUM_W'(wmag[LEN_W-1:0]) << IN_FRAC) + NUM_W'(len_reg >> 1);
    end

    cou_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .cos_out (cordic_cos),
        .sin_out (cordic_sin)
    );

    cou_root_div u_root_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (rd_cmd),
        .rad_in  (acc_reg[ROOT_W-1:0]),
        .num_in  (rd_num),
        .den_in  (len_reg),
        .done    (rd_done),
        .result  (rd_result)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FRONT;
            sens_reg    <= SENS_RESET;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            up_reg[0]   <= '0;
            up_reg[1]   <= FIELD_W'(1 << VECTOR_FRAC_BITS);
            up_reg[2]   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                sens_reg <= cfg_data;
            end
            // A new result loads the output register; otherwise an accepted
            // beat empties it.
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        x_reg     <= s_data.x_offset;
                        y_reg     <= s_data.y_offset;
                        state_reg <= ST_SCALE_X;
                    end
                end
                ST_SCALE_X: begin
                    state_reg <= ST_SCALE_Y;
                end
                ST_SCALE_Y: begin
                    dx_reg    <= rnd9[DELTA_W-1:0];
                    state_reg <= ST_ANGLES;
                end
                ST_ANGLES: begin
                    // The bias is a multiple of a full turn that keeps the sum positive.
                    wrap_reg <= ysum[WRAP_W-1:0];
                    if (psum > WRAP_W'(PITCH_LIM)) begin
                        pitch_reg <= PITCH_W'(PITCH_LIM);
                    end else if (psum < -WRAP_W'(PITCH_LIM)) begin
                        pitch_reg <= -PITCH_W'(PITCH_LIM);
                    end else begin
                        pitch_reg <= psum[PITCH_W-1:0];
                    end
                    k_reg     <= 4'(WRAP_STEPS - 1);
                    state_reg <= ST_WRAP;
                end
                ST_WRAP: begin
                    wrap_reg <= wrap_next;
                    k_reg    <= k_reg - 1'b1;
                    if (k_reg == '0) begin
                        yaw_reg   <= wrap_next[YAW_W-1:0];
                        state_reg <= ST_YAW_GO;
                    end
                end
                ST_YAW_GO: begin
                    state_reg <= ST_YAW_WAIT;
                end
                ST_YAW_WAIT: begin
                    if (cordic_done) begin
                        cy_reg    <= cordic_cos;
                        sy_reg    <= cordic_sin;
                        state_reg <= ST_PITCH_GO;
                    end
                end
                ST_PITCH_GO: begin
                    state_reg <= ST_PITCH_WAIT;
                end
                ST_PITCH_WAIT: begin
                    if (cordic_done) begin
                        cp_reg    <= cordic_cos;
                        sp_reg    <= cordic_sin;
                        state_reg <= ST_FRONT_A;
                    end
                end
                ST_FRONT_A: begin
                    state_reg <= ST_FRONT_B;
                end
                ST_FRONT_B: begin
                    w_reg[0]  <= round_q30(prod_reg);
                    state_reg <= ST_FRONT_C;
                end
                ST_FRONT_C: begin
                    w_reg[2]  <= round_q30(prod_reg);
                    w_reg[1]  <= sp_reg;
                    phase_reg <= PH_FRONT;
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    // Squares issue at counts zero to two and accumulate one count later.
                    if (cnt_reg != '0) begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd3) begin
                        state_reg <= ST_ROOT_GO;
                    end
                end
                ST_ROOT_GO: begin
                    state_reg <= ST_ROOT_WAIT;
                end
                ST_ROOT_WAIT: begin
                    if (rd_done) begin
                        len_reg   <= rd_result;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: begin
                    if (len_reg == '0) begin
                        // A zero-length vector normalizes to zero.
                        w_reg[cnt_reg[1:0]] <= '0;
                        cnt_reg             <= cnt_reg + 1'b1;
                        if (cnt_reg == 3'd2) begin
                            state_reg <= ST_NORM_DONE;
                        end
                    end else begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (rd_done) begin
                        if (w_reg[cnt_reg[1:0]][VW-1]) begin
                            w_reg[cnt_reg[1:0]] <= -vec_t'(rd_result);
                        end else begin
                            w_reg[cnt_reg[1:0]] <= vec_t'(rd_result);
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == 3'd2) begin
                            state_reg <= ST_NORM_DONE;
                        end else begin
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_NORM_DONE: begin
                    cnt_reg <= '0;
                    unique case (phase_reg)
                        PH_FRONT: begin
                            front_reg <= w_reg;
                            phase_reg <= PH_RIGHT;
                            state_reg <= ST_CROSS;
                        end
                        PH_RIGHT: begin
                            right_reg <= w_reg;
                            phase_reg <= PH_UP;
                            state_reg <= ST_CROSS;
                        end
                        default: begin
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_CROSS: begin
                    // Products issue at counts zero to five; each pair forms one
                    // component as the first product minus the second.
                    if (cnt_reg != '0) begin
                        if (!jdx[0]) begin
                            acc_reg <= prod_reg;
                        end else begin
                            w_reg[jdx[2:1]] <= round_q30(acc_reg - prod_reg);
                        end
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd6) begin
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg.front_x <= to_out(front_reg[0]);
                        m_data_reg.front_y <= to_out(front_reg[1]);
                        m_data_reg.front_z <= to_out(front_reg[2]);
                        m_data_reg.right_x <= to_out(right_reg[0]);
                        m_data_reg.right_y <= to_out(right_reg[1]);
                        m_data_reg.right_z <= to_out(right_reg[2]);
                        m_data_reg.up_x    <= to_out(w_reg[0]);
                        m_data_reg.up_y    <= to_out(w_reg[1]);
                        m_data_reg.up_z    <= to_out(w_reg[2]);
                        for (int i = 0; i < 3; i++) begin
                            up_reg[i] <= to_out(w_reg[i]);
                        end
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
